// File: sv/icpr_pkg.sv
// ----------------------------------------------------------------------------
// icpr_pkg
// Shared types and constants for the ICMP probe reply classifier.
// ----------------------------------------------------------------------------
package icpr_pkg;

   // Byte position saturates at this bound.
   localparam int MAX_PACKET_BYTES = 1024;
   localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
   // Offset arithmetic must hold both the position and H + 8 + L (up to 128).
   localparam int CMP_W            = ((POS_W > 8) ? POS_W : 8) + 1;

   localparam int HDR_W            = 6;
   localparam int ICMP_HDR_BYTES   = 8;

   localparam logic [7:0] ICMP_TYPE_ECHO_REPLY = 8'd0;
   localparam logic [7:0] ICMP_TIME_EXCEEDED   = 8'd11;

   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_ID  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_SEQ = 1'd1;

   localparam int RSP_DATA_W = 72;

   typedef enum logic [2:0] {
      STATUS_ECHO_MATCH = 3'd0,
      STATUS_TE_MATCH   = 3'd1,
      STATUS_TOO_SHORT  = 3'd2,
      STATUS_OTHER_TYPE = 3'd3,
      STATUS_MISMATCH   = 3'd4
   } status_type;

   typedef struct packed {
      logic [31:0] dest_ip;
      logic [31:0] src_ip;
      status_type  status;
   } result_type;

endpackage

// File: sv/icpr_parser.sv
// ----------------------------------------------------------------------------
// icpr_parser
// Per-packet header walker: captures addresses, type, id and sequence, and
// builds the classification on the last byte.
// ----------------------------------------------------------------------------
module icpr_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_take,
   input  logic [7:0]             pkt_byte,
   input  logic                   pkt_last,
   input  logic [15:0]            expected_id,
   input  logic [15:0]            expected_seq,
   output logic                   res_valid,
   output icpr_pkg::result_type   res
);

   logic [icpr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [icpr_pkg::HDR_W-1:0] outer_ff, outer_in;
   logic [icpr_pkg::HDR_W-1:0] inner_ff, inner_in;
   logic [7:0]                 type_ff, type_in;
   logic [15:0]                id_ff, id_in;
   logic [15:0]                seq_ff, seq_in;
   logic [31:0]                src_ff, src_in;
   logic [31:0]                dst_ff, dst_in;
   logic                       complete_ff, complete_in;

   always_comb begin
      logic [icpr_pkg::CMP_W-1:0] p;
      logic [icpr_pkg::CMP_W-1:0] h;
      logic [icpr_pkg::CMP_W-1:0] inner_start;
      logic [icpr_pkg::CMP_W-1:0] rel;
      logic                       take;

      pos_in      = pos_ff;
      outer_in    = outer_ff;
      inner_in    = inner_ff;
      type_in     = type_ff;
      id_in       = id_ff;
      seq_in      = seq_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      complete_in = complete_ff;
      take        = 1'b0;
      rel         = '0;
      inner_start = '0;
      p           = icpr_pkg::CMP_W'(pos_ff);
      h           = '0;
      res_valid   = 1'b0;
      res         = '0;

      if (byte_take && (pos_ff < icpr_pkg::POS_W'(icpr_pkg::MAX_PACKET_BYTES))) begin
         pos_in = pos_ff + icpr_pkg::POS_W'(1);
         if (pos_ff == '0) begin
            outer_in = {pkt_byte[3:0], 2'b00};
         end
         h = icpr_pkg::CMP_W'(outer_in);
         if ((p >= icpr_pkg::CMP_W'(12)) && (p <= icpr_pkg::CMP_W'(15))) begin
            src_in = {src_ff[23:0], pkt_byte};
         end
         if ((p >= icpr_pkg::CMP_W'(16)) && (p <= icpr_pkg::CMP_W'(19))) begin
            dst_in = {dst_ff[23:0], pkt_byte};
         end
         if (p == h) begin
            type_in = pkt_byte;
         end
         if (p >= h) begin
            if (type_in == icpr_pkg::ICMP_TYPE_ECHO_REPLY) begin
               if ((p - h) < icpr_pkg::CMP_W'(icpr_pkg::ICMP_HDR_BYTES)) begin
                  take = 1'b1;
                  rel  = p - h;
               end
            end else if (type_in == icpr_pkg::ICMP_TIME_EXCEEDED) begin
               if (p == h + icpr_pkg::CMP_W'(icpr_pkg::ICMP_HDR_BYTES)) begin
                  inner_in = {pkt_byte[3:0], 2'b00};
               end
               inner_start = h + icpr_pkg::CMP_W'(icpr_pkg::ICMP_HDR_BYTES)
                           + icpr_pkg::CMP_W'(inner_in);
               if ((p >= inner_start) &&
                   ((p - inner_start) < icpr_pkg::CMP_W'(icpr_pkg::ICMP_HDR_BYTES))) begin
                  take = 1'b1;
                  rel  = p - inner_start;
               end
            end
         end
         if (take) begin
            case (rel[2:0])
               3'd4, 3'd5: id_in  = {id_ff[7:0], pkt_byte};
               3'd6:       seq_in = {seq_ff[7:0], pkt_byte};
               3'd7: begin
                  seq_in      = {seq_ff[7:0], pkt_byte};
                  complete_in = 1'b1;
               end
               default: ;
            endcase
         end
      end

      if (byte_take && pkt_last) begin
         res_valid     = 1'b1;
         res.src_ip    = src_in;
         res.dest_ip   = dst_in;
         if (icpr_pkg::CMP_W'(pos_in) <
             icpr_pkg::CMP_W'(outer_in) + icpr_pkg::CMP_W'(icpr_pkg::ICMP_HDR_BYTES)) begin
            res.status = icpr_pkg::STATUS_TOO_SHORT;
         end else if ((type_in != icpr_pkg::ICMP_TYPE_ECHO_REPLY) &&
                      (type_in != icpr_pkg::ICMP_TIME_EXCEEDED)) begin
            res.status = icpr_pkg::STATUS_OTHER_TYPE;
         end else if (!complete_in) begin
            res.status = icpr_pkg::STATUS_TOO_SHORT;
         end else if ((id_in != expected_id) || (seq_in != expected_seq)) begin
            res.status = icpr_pkg::STATUS_MISMATCH;
         end else if (type_in == icpr_pkg::ICMP_TYPE_ECHO_REPLY) begin
            res.status = icpr_pkg::STATUS_ECHO_MATCH;
         end else begin
            res.status = icpr_pkg::STATUS_TE_MATCH;
         end
         // The packet is finished, so the next byte starts a fresh walk.
         pos_in      = '0;
         outer_in    = '0;
         inner_in    = '0;
         type_in     = '0;
         id_in       = '0;
         seq_in      = '0;
         src_in      = '0;
         dst_in      = '0;
         complete_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         outer_ff    <= '0;
         inner_ff    <= '0;
         type_ff     <= '0;
         id_ff       <= '0;
         seq_ff      <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         complete_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         outer_ff    <= outer_in;
         inner_ff    <= inner_in;
         type_ff     <= type_in;
         id_ff       <= id_in;
         seq_ff      <= seq_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         complete_ff <= complete_in;
      end
   end

   a_pos_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      (byte_take && pkt_last) |=> (pos_ff == '0))
      else $error("byte position not cleared after last byte");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= icpr_pkg::POS_W'(icpr_pkg::MAX_PACKET_BYTES))
      else $error("byte position beyond its bound");

   a_complete_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> (pos_ff >= icpr_pkg::POS_W'(icpr_pkg::ICMP_HDR_BYTES)))
      else $error("fields complete before eight bytes arrived");

endmodule

// File: sv/icpr_out_buf.sv
// ----------------------------------------------------------------------------
// icpr_out_buf
// Two-entry result buffer that decouples the response side from the input.
// ----------------------------------------------------------------------------
module icpr_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   input  icpr_pkg::result_type wr_data,
   output logic                 has_room,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output icpr_pkg::result_type rd_data
);

   icpr_pkg::result_type entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 rd_take;
   logic                 wr_take;

   assign has_room = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign rd_take  = rd_valid && rd_ready;
   assign wr_take  = wr_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_take;
      rd_ptr_in = rd_ptr_ff ^ rd_take;
      count_in  = count_ff + {1'b0, wr_take} - {1'b0, rd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_take) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result buffer count out of range");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      wr_valid |-> has_room)
      else $error("result written into a full buffer");

   a_head_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rd_valid && !rd_ready) |=> (rd_valid && $stable(rd_data)))
      else $error("head result changed while stalled");

endmodule

// File: sv/icmp_probe_reply_classifier.sv
// ----------------------------------------------------------------------------
// icmp_probe_reply_classifier
// Classifies a received IPv4 packet as a reply to an outstanding probe.
//
//   Channel  Direction  Beat contents
//   req_     in         tdata: pkt_byte; tlast: last byte of the packet
//   rsp_     out        tdata: status, src_ip, dest_ip (one per packet)
//   csr_     in         index 0 expected_id, index 1 expected_seq
//
// One packet byte is taken every cycle while the result buffer has room;
// the per-byte work is a single pass through compare and capture logic
// ahead of the parser state registers; rsp_ reads from the result buffer.
// Reset is synchronous and clears all packet state and both registers.
// The two-entry result buffer stalls req_ only when it holds two results.
// ----------------------------------------------------------------------------
module icmp_probe_reply_classifier (
   input  logic                                  clock,
   input  logic                                  reset,
   // tdata[7:0] pkt_byte
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   input  logic                                  req_tlast,
   // tdata[2:0] status, [34:3] src_ip, [66:35] dest_ip, [71:67] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [icpr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [icpr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [15:0]                           csr_data
);

   logic [15:0]          exp_id_ff, exp_id_in;
   logic [15:0]          exp_seq_ff, exp_seq_in;
   logic                 byte_take;
   logic                 has_room;
   logic                 res_valid;
   icpr_pkg::result_type res;
   icpr_pkg::result_type head;

   assign csr_ready  = 1'b1;
   assign req_tready = has_room;
   assign byte_take  = req_tvalid && has_room;

   always_comb begin
      exp_id_in  = exp_id_ff;
      exp_seq_in = exp_seq_ff;
      if (csr_valid) begin
         case (csr_index)
            icpr_pkg::CSR_EXPECTED_ID:  exp_id_in  = csr_data;
            icpr_pkg::CSR_EXPECTED_SEQ: exp_seq_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_id_ff  <= '0;
         exp_seq_ff <= '0;
      end else begin
         exp_id_ff  <= exp_id_in;
         exp_seq_ff <= exp_seq_in;
      end
   end

   icpr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_take    (byte_take),
      .pkt_byte     (req_tdata),
      .pkt_last     (req_tlast),
      .expected_id  (exp_id_ff),
      .expected_seq (exp_seq_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   icpr_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (res_valid),
      .wr_data  (res),
      .has_room (has_room),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (head)
   );

   assign rsp_tdata = {5'b0, head.dest_ip, head.src_ip, head.status};

endmodule
